/* rtl/assert_macros.svh */
// Assertion macros shared by the RTL of the sprite projection block.
// No dependencies; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMM(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/ssp_pkg.sv */
// Constants, types and the divider step shared by the sprite projection block.
// No dependencies.
package ssp_pkg;

    localparam int SCREEN_W = 1024;
    localparam int SCREEN_H = 768;

    // Magnitude widths of the three dividers (numerator, divisor, remainder).
    localparam int NUM_W     = 56;
    localparam int DEN_W     = 40;
    localparam int REM_W     = DEN_W + 1;
    localparam int DIV_STEPS = NUM_W;

    localparam int IN_W   = 128;
    localparam int OUT_W  = 120;
    localparam int USER_W = 2;

    // One restoring divider lane: the numerator register collects quotient bits.
    typedef struct packed {
        logic [NUM_W-1:0] num;
        logic [REM_W-1:0] rem;
        logic [DEN_W-1:0] den;
    } div_t;

    // One restoring division step: bring in one numerator bit, subtract if it fits.
    function automatic div_t div_step(input div_t d);
        div_t             r;
        logic [REM_W-1:0] rem_sh;
        rem_sh = {d.rem[REM_W-2:0], d.num[NUM_W-1]};
        r.den  = d.den;
        r.num  = {d.num[NUM_W-2:0], 1'b0};
        r.rem  = rem_sh;
        if (rem_sh >= {1'b0, d.den}) begin
            r.rem    = rem_sh - {1'b0, d.den};
            r.num[0] = 1'b1;
        end
        return r;
    endfunction

    // Magnitude of a signed numerator-width value.
    function automatic logic [NUM_W-1:0] abs_num(input logic signed [NUM_W-1:0] v);
        logic [NUM_W-1:0] r;
        r = v[NUM_W-1] ? NUM_W'(-v) : NUM_W'(v);
        return r;
    endfunction

endpackage

/* rtl/sprite_screen_projection.sv */
// Top level of the sprite projection block: camera transform, divider pipeline, bounds.
// Depends on ssp_pkg and assert_macros.svh.
//
// Projects one sprite per word into camera space and screen bounds. A new word is
// accepted every cycle unless the pipeline stalls. The accepting edge loads the
// offset subtraction. After that come a multiply stage, a subtract stage, divider
// setup, 56 one-bit restoring divider stages that serve depth, centre column and
// size side by side, a sign and saturation stage, and the output register. The
// pipeline keeps accepting words while a result waits at the output, and stops
// only when the last stage holds a word that the full output register cannot take.
`include "assert_macros.svh"

module sprite_screen_projection import ssp_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    // obj_x, obj_y, viewer_x, viewer_y, dir_x, dir_y, plane_x, plane_y (16 bits each)
    input  logic [IN_W-1:0]   s_tdata,
    input  logic              s_tvalid,
    output logic              s_tready,
    // depth[31:0], centre_col[47:32], proj_size[63:48], top_row[72:64],
    // bottom_row[82:73], left_col[97:83], right_col[113:98], zero pad to 119
    output logic [OUT_W-1:0]  m_tdata,
    // visible[0], degenerate[1]
    output logic [USER_W-1:0] m_tuser,
    output logic              m_tvalid,
    input  logic              m_tready
);

    localparam logic signed [17:0] HALF_H_S = 18'(SCREEN_H / 2);
    localparam logic signed [17:0] H_S      = 18'(SCREEN_H);
    localparam logic signed [17:0] W_S      = 18'(SCREEN_W);

    // Pipeline control.
    logic out_free, en;
    logic v1_reg, v2_reg, v3_reg, post_v_reg, m_tvalid_reg;
    logic [DIV_STEPS:0] dv_v_reg;

    assign out_free = !m_tvalid_reg || m_tready;
    assign en       = out_free || !post_v_reg;
    assign s_tready = en;

    // Stage 1: offsets of the sprite from the viewer.
    logic signed [16:0] sx_reg, sy_reg;
    logic signed [15:0] dx1_reg, dy1_reg, px1_reg, py1_reg;
    logic signed [15:0] ox, oy, vx, vy;
    assign ox = s_tdata[15:0];
    assign oy = s_tdata[31:16];
    assign vx = s_tdata[47:32];
    assign vy = s_tdata[63:48];

    always_ff @(posedge aclk) begin
        if (en) begin
            sx_reg  <= 17'(ox) - 17'(vx);
            sy_reg  <= 17'(oy) - 17'(vy);
            dx1_reg <= s_tdata[79:64];
            dy1_reg <= s_tdata[95:80];
            px1_reg <= s_tdata[111:96];
            py1_reg <= s_tdata[127:112];
        end
    end

    // Stage 2: the six products of the camera matrix inverse.
    logic signed [31:0] pxdy_reg, dxpy_reg;
    logic signed [32:0] dysx_reg, dxsy_reg, pxsy_reg, pysx_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            pxdy_reg <= px1_reg * dy1_reg;
            dxpy_reg <= dx1_reg * py1_reg;
            dysx_reg <= 33'(dy1_reg) * sx_reg;
            dxsy_reg <= 33'(dx1_reg) * sy_reg;
            pxsy_reg <= 33'(px1_reg) * sy_reg;
            pysx_reg <= 33'(py1_reg) * sx_reg;
        end
    end

    // Stage 3: determinant and the two transformed numerators.
    logic signed [32:0] det_reg;
    logic signed [33:0] nx_reg, ny_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            det_reg <= 33'(pxdy_reg) - 33'(dxpy_reg);
            nx_reg  <= 34'(dysx_reg) - 34'(dxsy_reg);
            ny_reg  <= 34'(pxsy_reg) - 34'(pysx_reg);
        end
    end

    // Divider setup: magnitudes for the three divisions, quotient signs for depth and centre.
    logic signed [NUM_W-1:0] ny_w, det_w, sum_w;
    div_t dz_depth, dz_centre, dz_size;

    assign ny_w  = NUM_W'(ny_reg);
    assign det_w = NUM_W'(det_reg);
    assign sum_w = NUM_W'(ny_reg) + NUM_W'(nx_reg);

    always_comb begin
        dz_depth.num  = abs_num(ny_w) << 22;
        dz_depth.rem  = '0;
        dz_depth.den  = DEN_W'(abs_num(det_w));
        dz_centre.num = abs_num(sum_w * NUM_W'(SCREEN_W / 2));
        dz_centre.rem = '0;
        dz_centre.den = DEN_W'(abs_num(ny_w));
        dz_size.num   = abs_num(det_w * NUM_W'(SCREEN_H));
        dz_size.rem   = '0;
        dz_size.den   = DEN_W'(abs_num(ny_w)) << 6;
    end

    // Divider pipeline: index k holds the lanes after k steps.
    div_t dv_depth_reg  [DIV_STEPS+1];
    div_t dv_centre_reg [DIV_STEPS+1];
    div_t dv_size_reg   [DIV_STEPS+1];
    logic [DIV_STEPS:0] neg_depth_reg, neg_centre_reg, det_zero_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_depth_reg[0]   <= dz_depth;
            dv_centre_reg[0]  <= dz_centre;
            dv_size_reg[0]    <= dz_size;
            neg_depth_reg[0]  <= ny_reg[33] ^ det_reg[32];
            neg_centre_reg[0] <= sum_w[NUM_W-1] ^ ny_reg[33];
            det_zero_reg[0]   <= (det_reg == '0);
            for (int k = 1; k <= DIV_STEPS; k++) begin
                dv_depth_reg[k]   <= div_step(dv_depth_reg[k-1]);
                dv_centre_reg[k]  <= div_step(dv_centre_reg[k-1]);
                dv_size_reg[k]    <= div_step(dv_size_reg[k-1]);
                neg_depth_reg[k]  <= neg_depth_reg[k-1];
                neg_centre_reg[k] <= neg_centre_reg[k-1];
                det_zero_reg[k]   <= det_zero_reg[k-1];
            end
        end
    end

    // Sign, saturation and the degenerate cases.
    logic [NUM_W-1:0]   qd, qc, qs;
    logic signed [31:0] depth_sat;
    logic signed [15:0] centre_sat;
    logic [15:0]        size_sat;
    logic               degen_c;
    logic signed [31:0] depth_reg;
    logic signed [15:0] centre_reg;
    logic [15:0]        size_reg;
    logic               degen_reg, vis_reg;

    assign qd = dv_depth_reg[DIV_STEPS].num;
    assign qc = dv_centre_reg[DIV_STEPS].num;
    assign qs = dv_size_reg[DIV_STEPS].num;

    always_comb begin
        if (neg_depth_reg[DIV_STEPS]) begin
            depth_sat = (qd > NUM_W'(64'h8000_0000)) ? 32'sh8000_0000 : -$signed(qd[31:0]);
        end else begin
            depth_sat = (qd > NUM_W'(64'h7FFF_FFFF)) ? 32'sh7FFF_FFFF : $signed(qd[31:0]);
        end
        if (neg_centre_reg[DIV_STEPS]) begin
            centre_sat = (qc > NUM_W'(32768)) ? 16'sh8000 : -$signed(qc[15:0]);
        end else begin
            centre_sat = (qc > NUM_W'(32767)) ? 16'sh7FFF : $signed(qc[15:0]);
        end
        size_sat = (qs > NUM_W'(65535)) ? 16'hFFFF : qs[15:0];
        degen_c  = det_zero_reg[DIV_STEPS] || (depth_sat == '0);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            depth_reg  <= degen_c ? '0 : depth_sat;
            centre_reg <= degen_c ? '0 : centre_sat;
            size_reg   <= degen_c ? '0 : size_sat;
            degen_reg  <= degen_c;
            vis_reg    <= !degen_c && !depth_sat[31];
        end
    end

    // Draw bounds from size and centre.
    logic signed [17:0] hs, top_s, bot_s, left_s, right_s;
    logic [8:0]  top_c;
    logic [9:0]  bot_c;
    logic [14:0] left_c;
    logic [15:0] right_c;

    always_comb begin
        hs      = 18'(size_reg >> 1);
        top_s   = HALF_H_S - hs;
        bot_s   = HALF_H_S + hs;
        left_s  = 18'(centre_reg) - hs;
        right_s = 18'(centre_reg) + hs;
        top_c   = top_s[17] ? '0 : top_s[8:0];
        bot_c   = (bot_s >= H_S) ? 10'(SCREEN_H - 1) : bot_s[9:0];
        left_c  = left_s[17] ? '0 : left_s[14:0];
        right_c = (right_s >= W_S) ? 16'(SCREEN_W - 1) : right_s[15:0];
    end

    // Output register.
    logic [OUT_W-1:0]  m_tdata_reg;
    logic [USER_W-1:0] m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (out_free) begin
            m_tdata_reg <= {6'b0, right_c, left_c, bot_c, top_c, size_reg,
                            centre_reg, depth_reg};
            m_tuser_reg <= {degen_reg, vis_reg};
        end
    end

    // Valid bits travel with the words.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            dv_v_reg     <= '0;
            post_v_reg   <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (en) begin
                v1_reg     <= s_tvalid;
                v2_reg     <= v1_reg;
                v3_reg     <= v2_reg;
                dv_v_reg   <= {dv_v_reg[DIV_STEPS-1:0], v3_reg};
                post_v_reg <= dv_v_reg[DIV_STEPS];
            end
            if (out_free) begin
                m_tvalid_reg <= post_v_reg;
            end
        end
    end

    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tvalid = m_tvalid_reg;

    // Checks on the pipeline and result flags.
    `CHK_IMM(a_vis_not_degen, aclk, aresetn, m_tvalid, !(m_tuser[0] && m_tuser[1]), "visible and degenerate together")
    `CHK_IMM(a_degen_zero, aclk, aresetn, m_tvalid && m_tuser[1], m_tdata[63:0] == '0, "degenerate result not zeroed")
    `CHK_IMM(a_stall_cause, aclk, aresetn, !s_tready, m_tvalid_reg && !m_tready && post_v_reg, "stall without a blocked result")
    `CHK_NXT(a_post_moves, aclk, aresetn, post_v_reg && out_free, m_tvalid_reg, "finished word not moved to output")

endmodule

/* sim/sprite_projection_checker.sv */
`timescale 1ns / 1ps
// Checker for the sprite projection block: watches both stream channels,
// predicts each result from the accepted input word and compares field by field.
// Depends on ssp_pkg for the screen size and the channel widths.
module sprite_projection_checker import ssp_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [IN_W-1:0]   s_tdata,
    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [OUT_W-1:0]  m_tdata,
    input  logic [USER_W-1:0] m_tuser,
    input  logic              m_tvalid,
    input  logic              m_tready,
    output int                fail_count,
    output int                pending_count
);

    typedef struct packed {
        logic [USER_W-1:0] user;
        logic [OUT_W-1:0]  data;
    } projection_t;

    projection_t projections_due[$];

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        return (v < lo) ? lo : ((v > hi) ? hi : v);
    endfunction

    // Exact integer projection of one sprite word.
    function automatic projection_t project_sprite(input logic [IN_W-1:0] w);
        longint ox, oy, vx, vy, dx, dy, px, py, sx, sy, det, nx, ny;
        longint dep, ctr, sz, hs, top, bot, lft, rgt, half_h, half_w;
        bit degen, vis;
        projection_t p;
        ox = longint'($signed(w[15:0]));
        oy = longint'($signed(w[31:16]));
        vx = longint'($signed(w[47:32]));
        vy = longint'($signed(w[63:48]));
        dx = longint'($signed(w[79:64]));
        dy = longint'($signed(w[95:80]));
        px = longint'($signed(w[111:96]));
        py = longint'($signed(w[127:112]));
        half_h = SCREEN_H / 2;
        half_w = SCREEN_W / 2;
        sx = ox - vx;
        sy = oy - vy;
        det = px * dy - dx * py;
        nx = dy * sx - dx * sy;
        ny = px * sy - py * sx;
        dep = 0;
        ctr = 0;
        sz = 0;
        if (det != 0) dep = clip((ny * 4194304) / det, -64'sd2147483648, 64'sd2147483647);
        degen = (det == 0) || (dep == 0);
        vis = !degen && dep > 0;
        if (!degen) begin
            ctr = clip((half_w * (ny + nx)) / ny, -32768, 32767);
            sz = (longint'(SCREEN_H) * det) / (ny * 64);
            if (sz < 0) sz = -sz;
            if (sz > 65535) sz = 65535;
        end else begin
            dep = 0;
        end
        hs = sz / 2;
        top = half_h - hs;
        if (top < 0) top = 0;
        bot = half_h + hs;
        if (bot >= SCREEN_H) bot = SCREEN_H - 1;
        lft = ctr - hs;
        if (lft < 0) lft = 0;
        rgt = ctr + hs;
        if (rgt >= SCREEN_W) rgt = SCREEN_W - 1;
        p.data = '0;
        p.data[31:0] = dep[31:0];
        p.data[47:32] = ctr[15:0];
        p.data[63:48] = sz[15:0];
        p.data[72:64] = top[8:0];
        p.data[82:73] = bot[9:0];
        p.data[97:83] = lft[14:0];
        p.data[113:98] = rgt[15:0];
        p.user = {degen, vis};
        return p;
    endfunction

    // Reports one field mismatch; only the first ten are printed.
    task automatic flag_field(input string name, input longint exp_v, input longint got_v);
        if (fail_count < 10)
            $display("mismatch in %s: expected %0h, got %0h", name, exp_v, got_v);
        fail_count++;
    endtask

    // Record expectations on accepted input words, compare accepted results.
    always @(posedge aclk) begin
        projection_t e;
        if (!aresetn) begin
            fail_count = 0;
        end else begin
            if (s_tvalid && s_tready)
                projections_due.push_back(project_sprite(s_tdata));
            if (m_tvalid && m_tready) begin
                if (projections_due.size() == 0) begin
                    if (fail_count < 10) $display("mismatch: result word with none expected");
                    fail_count++;
                end else begin
                    e = projections_due.pop_front();
                    if (m_tdata[31:0] !== e.data[31:0])
                        flag_field("depth", e.data[31:0], m_tdata[31:0]);
                    if (m_tdata[47:32] !== e.data[47:32])
                        flag_field("centre_col", e.data[47:32], m_tdata[47:32]);
                    if (m_tdata[63:48] !== e.data[63:48])
                        flag_field("proj_size", e.data[63:48], m_tdata[63:48]);
                    if (m_tdata[72:64] !== e.data[72:64])
                        flag_field("top_row", e.data[72:64], m_tdata[72:64]);
                    if (m_tdata[82:73] !== e.data[82:73])
                        flag_field("bottom_row", e.data[82:73], m_tdata[82:73]);
                    if (m_tdata[97:83] !== e.data[97:83])
                        flag_field("left_col", e.data[97:83], m_tdata[97:83]);
                    if (m_tdata[113:98] !== e.data[113:98])
                        flag_field("right_col", e.data[113:98], m_tdata[113:98]);
                    if (m_tuser[0] !== e.user[0])
                        flag_field("visible", e.user[0], m_tuser[0]);
                    if (m_tuser[1] !== e.user[1])
                        flag_field("degenerate", e.user[1], m_tuser[1]);
                end
            end
        end
        pending_count = projections_due.size();
    end

endmodule

/* sim/tb_sprite_screen_projection.sv */
`timescale 1ns / 1ps
// Testbench top for the sprite projection block: clock, reset, stimulus and verdict.
// Depends on ssp_pkg, the block itself and sprite_projection_checker.
module tb_sprite_screen_projection import ssp_pkg::*; ();

    localparam int RANDOM_WORDS = 2000;
    localparam int DRAIN_CYCLES = 100;

    logic              aclk;
    logic              aresetn;
    logic [IN_W-1:0]   s_tdata;
    logic              s_tvalid;
    logic              s_tready;
    logic [OUT_W-1:0]  m_tdata;
    logic [USER_W-1:0] m_tuser;
    logic              m_tvalid;
    logic              m_tready;
    int                fail_count;
    int                pending_count;
    bit                long_hold;

    sprite_screen_projection uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready)
    );

    sprite_projection_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tuser(m_tuser), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver: random stalls per word, plus one long hold-off to fill the pipeline.
    initial begin
        int gap;
        m_tready = 1'b0;
        wait (aresetn);
        forever begin
            @(negedge aclk);
            if (long_hold) begin
                m_tready <= 1'b0;
                repeat (300) @(negedge aclk);
                long_hold = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
                @(negedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // Offers one word, after a random gap unless no_gap is set, and waits for it to be taken.
    task automatic send_sprite(input logic [IN_W-1:0] w, input bit no_gap);
        int gap;
        gap = no_gap ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  <= w;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    function automatic logic [15:0] rand_field();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'($urandom_range(0, 15)) - 16'd8;
            default: return 16'($urandom);
        endcase
    endfunction

    // A plausible camera: unit-ish direction and plane vectors, nearby sprite.
    function automatic logic [IN_W-1:0] rand_scene();
        logic [15:0] f [8];
        logic [IN_W-1:0] w;
        f[2] = 16'($urandom_range(0, 16'hffff));
        f[3] = 16'($urandom_range(0, 16'hffff));
        f[0] = f[2] + 16'($signed(16'($urandom_range(0, 8191)) - 16'd4096));
        f[1] = f[3] + 16'($signed(16'($urandom_range(0, 8191)) - 16'd4096));
        f[4] = 16'($urandom_range(0, 32767)) - 16'd16384;
        f[5] = 16'($urandom_range(0, 32767)) - 16'd16384;
        f[6] = 16'($urandom_range(0, 21000)) - 16'd10500;
        f[7] = 16'($urandom_range(0, 21000)) - 16'd10500;
        for (int i = 0; i < 8; i++) w[16*i +: 16] = f[i];
        return w;
    endfunction

    initial begin
        logic [IN_W-1:0] w;
        logic [IN_W-1:0] directed [$];
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        long_hold = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed words: zero determinant, zero depth, sprite ahead and behind,
        // huge and tiny sizes, and every field at its extremes.
        directed.push_back('0);
        directed.push_back({16'h0000, 16'h2000, 16'h4000, 16'h0000,
                            16'h0000, 16'h0000, 16'h0100, 16'h0000});
        directed.push_back({16'h0000, 16'h2000, 16'h4000, 16'h0000,
                            16'h0000, 16'h0000, 16'hff00, 16'h0000});
        directed.push_back({16'h0000, 16'h2000, 16'h4000, 16'h0000,
                            16'h0000, 16'h0000, 16'h0001, 16'h0000});
        directed.push_back({16'h0000, 16'h2000, 16'h4000, 16'h0000,
                            16'h0000, 16'h0000, 16'h0100, 16'h0300});
        directed.push_back({16'h0000, 16'h2000, 16'h4000, 16'h0000,
                            16'h0000, 16'h0000, 16'h0010, 16'h7fff});
        directed.push_back({16'h0000, 16'h2000, 16'h4000, 16'h0000,
                            16'h8000, 16'h8000, 16'h7fff, 16'h7fff});
        directed.push_back({16'h4000, 16'h4000, 16'h2000, 16'h2000,
                            16'h0000, 16'h0000, 16'h0100, 16'h0100});
        directed.push_back({8{16'h7fff}});
        directed.push_back({8{16'h8000}});
        directed.push_back({8{16'hffff}});
        directed.push_back({16'h8000, 16'h7fff, 16'h7fff, 16'h8000,
                            16'h7fff, 16'h8000, 16'h8000, 16'h7fff});
        directed.push_back({16'h7fff, 16'h8000, 16'h8000, 16'h7fff,
                            16'h8000, 16'h7fff, 16'h7fff, 16'h8000});
        directed.push_back({16'h0000, 16'h2000, 16'h4000, 16'h0000,
                            16'h0000, 16'h0000, 16'h0000, 16'h7fff});
        foreach (directed[i]) send_sprite(directed[i], 1'b0);

        // Random words; partway through, a long receiver stall and a full drain pause.
        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == 500) long_hold = 1'b1;
            if (n == 1200) begin
                s_tvalid <= 1'b0;
                while (pending_count != 0) @(negedge aclk);
            end
            w = '0;
            if ($urandom_range(0, 3) == 0)
                for (int i = 0; i < 8; i++) w[16*i +: 16] = rand_field();
            else
                w = rand_scene();
            send_sprite(w, (n >= 1500 && n < 1600));
        end
        s_tvalid <= 1'b0;

        while (pending_count != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fail_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // Run limit.
    initial begin
        #5ms;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
